FILE: sv/clt_pkg.sv
// Shared constants, request and status codes, and the cell control word for the list table.
package clt_pkg;

   localparam int DEPTH    = 256;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int HANDLE_W = 32;
   localparam int GROUP    = 16;
   localparam int NGROUP   = DEPTH / GROUP;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_SET    = 2'd2;
   localparam logic [1:0] OP_REMOVE = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_RANGE  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   typedef struct packed {
      logic                phase_a;
      logic                phase_c;
      logic [1:0]          op;
      logic [IDX_W-1:0]    pos;
      logic [CNT_W-1:0]    count;
      logic [HANDLE_W-1:0] handle;
   } cell_ctl_type;

endpackage

FILE: sv/clt_cell.sv
// One list cell: holds an entry, flags a hit, and loads new data or its right neighbor.
module clt_cell
   import clt_pkg::*;
(
   input  logic                clock,
   input  logic [IDX_W-1:0]    cell_index,
   input  cell_ctl_type        ctl,
   input  logic [HANDLE_W-1:0] next_entry,
   input  logic                found_ge,
   output logic [HANDLE_W-1:0] entry,
   output logic                hit
);

   logic [HANDLE_W-1:0] entry_ff, entry_in;
   logic                hit_ff, hit_in;
   logic [CNT_W-1:0]    my_idx;
   logic                in_use;

   assign my_idx = {1'b0, cell_index};
   assign in_use = my_idx < ctl.count;

   always_comb begin
      hit_in = hit_ff;
      if (ctl.phase_a) begin
         case (ctl.op)
            OP_PUSH:   hit_in = (my_idx == ctl.count);
            OP_REMOVE: hit_in = in_use && (entry_ff == ctl.handle);
            default:   hit_in = in_use && (cell_index == ctl.pos);
         endcase
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.phase_c) begin
         case (ctl.op) inside
            OP_PUSH, OP_SET: if (hit_ff) entry_in = ctl.handle;
            OP_REMOVE:       if (found_ge) entry_in = next_entry;
            default:         entry_in = entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

FILE: sv/clt_group.sv
// A group of cells' hit bits: registered in-group prefix, any-hit flag and selected entry.
module clt_group
   import clt_pkg::*;
(
   input  logic                             clock,
   input  logic                             phase_b,
   input  logic [GROUP-1:0]                 hit,
   input  logic [GROUP-1:0][HANDLE_W-1:0]   entry,
   input  logic                             earlier,
   output logic [GROUP-1:0]                 found_ge,
   output logic                             any_hit,
   output logic [HANDLE_W-1:0]              rd_value
);

   logic [GROUP-1:0]    pre_ff, pre_in;
   logic                any_ff;
   logic [HANDLE_W-1:0] rd_ff, rd_in;

   always_comb begin
      pre_in[0] = hit[0];
      for (int k = 1; k < GROUP; k++) pre_in[k] = pre_in[k-1] | hit[k];
      rd_in = '0;
      for (int k = 0; k < GROUP; k++) rd_in = rd_in | (entry[k] & {HANDLE_W{hit[k]}});
   end

   always_ff @(posedge clock) begin
      if (phase_b) begin
         pre_ff <= pre_in;
         any_ff <= pre_in[GROUP-1];
         rd_ff  <= rd_in;
      end
   end

   assign found_ge = pre_ff | {GROUP{earlier}};
   assign any_hit  = any_ff;
   assign rd_value = rd_ff;

endmodule

FILE: sv/compacting_list_table_core.sv
// Top level of the compacting list table: request sequencer, cell row and result register.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_op, req_position, req_handle
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_read_value, rsp_fill_count, rsp_status
//
// Each request passes through four steps: accept, cell compare, group prefix, commit.
// One request is in flight; the input stalls until that request commits.
// A new request is taken while the previous result still waits in the output register.
// Commit holds while an older result is stalled. Reset clears the count and control only.
module compacting_list_table_core
   import clt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [7:0]          req_position,
   input  logic [31:0]         req_handle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_read_value,
   output logic [8:0]          rsp_fill_count,
   output logic [1:0]          rsp_status
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_A    = 2'd1;
   localparam logic [1:0] S_B    = 2'd2;
   localparam logic [1:0] S_C    = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          op_ff;
   logic [IDX_W-1:0]    pos_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] rd_out_ff, rd_out_in;
   logic [1:0]          status_ff, status_in;

   logic                accept;
   logic                commit;
   cell_ctl_type        ctl;

   logic [DEPTH-1:0][HANDLE_W-1:0]  entry;
   logic [DEPTH-1:0][HANDLE_W-1:0]  next_entry;
   logic [DEPTH-1:0]                hit;
   logic [DEPTH-1:0]                found_ge;
   logic [NGROUP-1:0]               any_hit;
   logic [NGROUP-1:0]               earlier;
   logic [NGROUP-1:0][HANDLE_W-1:0] grp_rd;
   logic [HANDLE_W-1:0]             rd_all;
   logic                            found_any;
   logic                            in_range;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == S_C) && (!rsp_valid_ff || !rsp_stall);

   assign ctl.phase_a = (state_ff == S_A);
   assign ctl.phase_c = commit;
   assign ctl.op      = op_ff;
   assign ctl.pos     = pos_ff;
   assign ctl.count   = count_ff;
   assign ctl.handle  = handle_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_A;
         S_A:     state_in = S_B;
         S_B:     state_in = S_C;
         S_C:     if (commit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_last
         assign next_entry[i] = entry[i];
      end else begin : g_mid
         assign next_entry[i] = entry[i+1];
      end
      clt_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .ctl        (ctl),
         .next_entry (next_entry[i]),
         .found_ge   (found_ge[i]),
         .entry      (entry[i]),
         .hit        (hit[i])
      );
   end

   for (genvar g = 0; g < NGROUP; g++) begin : g_group
      clt_group u_group (
         .clock    (clock),
         .phase_b  (state_ff == S_B),
         .hit      (hit[g*GROUP +: GROUP]),
         .entry    (entry[g*GROUP +: GROUP]),
         .earlier  (earlier[g]),
         .found_ge (found_ge[g*GROUP +: GROUP]),
         .any_hit  (any_hit[g]),
         .rd_value (grp_rd[g])
      );
   end

   // a match in any lower group shifts the whole group
   always_comb begin
      earlier[0] = 1'b0;
      for (int g = 1; g < NGROUP; g++) earlier[g] = earlier[g-1] | any_hit[g-1];
      rd_all = '0;
      for (int g = 0; g < NGROUP; g++) rd_all = rd_all | grp_rd[g];
   end

   assign found_any = |any_hit;
   assign in_range  = {1'b0, pos_ff} < count_ff;

   always_comb begin
      count_in     = count_ff;
      rd_out_in    = rd_out_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rd_out_in    = '0;
         status_in    = ST_OK;
         unique case (op_ff)
            OP_PUSH: begin
               if (count_ff == DEPTH_CNT) status_in = ST_FULL;
               else count_in = count_ff + CNT_W'(1);
            end
            OP_GET: begin
               if (!in_range) status_in = ST_RANGE;
               else rd_out_in = rd_all;
            end
            OP_SET: begin
               if (!in_range) status_in = ST_RANGE;
            end
            OP_REMOVE: begin
               if (!found_any) status_in = ST_ABSENT;
               else count_in = count_ff - CNT_W'(1);
            end
            default: status_in = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         pos_ff    <= req_position;
         handle_ff <= req_handle;
      end
      rd_out_ff <= rd_out_in;
      status_ff <= status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rd_out_ff;
   assign rsp_fill_count = count_ff;
   assign rsp_status     = status_ff;

endmodule

FILE: test/tb_compacting_list_table_core.sv
// Self-checking testbench for the compacting list table: queued stimulus, scoreboard, idling.
`timescale 1ns / 1ps

module tb_compacting_list_table_core
   import clt_pkg::*;
;

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  position;
      logic [31:0] handle;
      bit          wait_idle;   // hold this word back until the table has answered everything
   } list_request_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [8:0]  fill_count;
      logic [1:0]  status;
   } list_result_type;

   typedef enum int {GEN_MIX, GEN_FILL, GEN_DRAIN} gen_mode_type;

   localparam int RANDOM_ITEMS = 1100;
   localparam int SEGMENT      = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_PUSH;
   logic [7:0]  req_position = '0;
   logic [31:0] req_handle = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_value;
   logic [8:0]  rsp_fill_count;
   logic [1:0]  rsp_status;

   list_request_type pending_requests [$];
   list_result_type  expected_results [$];
   logic [31:0]      steer_list [$];      // rough picture of the contents, used to aim stimulus

   // predicted table contents
   logic [31:0]      table_mem [DEPTH];
   logic [CNT_W-1:0] table_count = '0;

   gen_mode_type seg_plan [11] = '{GEN_MIX, GEN_FILL, GEN_FILL, GEN_FILL, GEN_FILL, GEN_MIX,
                                   GEN_DRAIN, GEN_DRAIN, GEN_DRAIN, GEN_FILL, GEN_MIX};

   logic req_taken = 1'b0;
   bit   long_hold = 1'b0;
   int   total_reqs;
   int   accepted_reqs;
   int   checked_words;
   int   mismatches;
   int   drain_waits;
   int   peak_fill;
   int   op_seen [4];
   int   status_seen [4];

   compacting_list_table_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_position   (req_position),
      .req_handle     (req_handle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_fill_count (rsp_fill_count),
      .rsp_status     (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Applies one request to the predicted table and returns the word it should produce.
   function automatic list_result_type apply_list_request(input logic [1:0] op,
                                                          input logic [7:0] pos,
                                                          input logic [31:0] handle);
      list_result_type res;
      int i;
      int hit;
      res = '0;
      res.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (table_count >= DEPTH_CNT) begin
               res.status = ST_FULL;
            end else begin
               table_mem[table_count[IDX_W-1:0]] = handle;
               table_count = table_count + CNT_W'(1);
            end
         end
         OP_GET, OP_SET: begin
            if ({1'b0, pos} >= table_count) begin
               res.status = ST_RANGE;
            end else if (op == OP_GET) begin
               res.read_value = table_mem[pos];
            end else begin
               table_mem[pos] = handle;
            end
         end
         OP_REMOVE: begin
            hit = -1;
            for (i = 0; i < table_count; i++) begin
               if (hit < 0 && table_mem[IDX_W'(i)] == handle) hit = i;
            end
            if (hit < 0) begin
               res.status = ST_ABSENT;
            end else begin
               for (i = hit + 1; i < table_count; i++) begin
                  table_mem[IDX_W'(i - 1)] = table_mem[IDX_W'(i)];
               end
               table_count = table_count - CNT_W'(1);
            end
         end
      endcase
      res.fill_count = table_count;
      return res;
   endfunction

   task automatic queue_request(input logic [1:0] op, input logic [7:0] pos,
                                input logic [31:0] handle, input bit wait_idle);
      list_request_type r;
      int j;
      int hit;
      r.op = op;
      r.position = pos;
      r.handle = handle;
      r.wait_idle = wait_idle;
      pending_requests.push_back(r);
      case (op)
         OP_PUSH: begin
            if (steer_list.size() < DEPTH) steer_list.push_back(handle);
         end
         OP_SET: begin
            if (pos < steer_list.size()) steer_list[pos] = handle;
         end
         OP_REMOVE: begin
            hit = -1;
            for (j = 0; j < steer_list.size(); j++) begin
               if (hit < 0 && steer_list[j] == handle) hit = j;
            end
            if (hit >= 0) steer_list.delete(hit);
         end
         OP_GET: ;
      endcase
   endtask

   task automatic flag_mismatch(input string why, input list_result_type want,
                                input list_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected %h fill %0d status %0d, got %h fill %0d status %0d",
                  $realtime, why, want.read_value, want.fill_count, want.status,
                  got.read_value, got.fill_count, got.status);
      end
   endtask

   function automatic int idle_phase();
      if (accepted_reqs * 3 < total_reqs) return 0;
      if (accepted_reqs * 3 < total_reqs * 2) return 1;
      return 2;
   endfunction

   // stimulus: directed corner cases, then segments that fill, drain and mix
   initial begin
      logic [31:0]  pool [16];
      logic [1:0]   op;
      logic [7:0]   pos;
      logic [31:0]  handle;
      gen_mode_type mode;
      int           k;
      int           n;
      int           roll;
      int           pos_roll;

      queue_request(OP_GET, 8'd0, 32'h0, 1'b0);
      queue_request(OP_SET, 8'd0, 32'hFFFF_FFFF, 1'b0);
      queue_request(OP_REMOVE, 8'hFF, 32'h0, 1'b0);
      queue_request(OP_PUSH, 8'hFF, 32'h0, 1'b0);
      queue_request(OP_PUSH, 8'h00, 32'hFFFF_FFFF, 1'b0);
      queue_request(OP_PUSH, 8'h5A, 32'hA5A5_A5A5, 1'b0);
      queue_request(OP_PUSH, 8'hA5, 32'hFFFF_FFFF, 1'b0);
      queue_request(OP_GET, 8'd3, 32'hFFFF_FFFF, 1'b0);
      queue_request(OP_GET, 8'd4, 32'h0, 1'b0);
      queue_request(OP_GET, 8'd255, 32'h0, 1'b0);
      queue_request(OP_SET, 8'd2, 32'h5A5A_5A5A, 1'b0);
      queue_request(OP_SET, 8'd4, $urandom, 1'b0);
      // duplicates: only the lowest copy goes
      queue_request(OP_REMOVE, 8'd0, 32'hFFFF_FFFF, 1'b0);
      queue_request(OP_GET, 8'd1, 32'h0, 1'b0);
      queue_request(OP_GET, 8'd2, 32'h0, 1'b0);
      queue_request(OP_REMOVE, 8'd0, 32'hDEAD_BEEF, 1'b0);
      queue_request(OP_REMOVE, 8'd0, 32'h0, 1'b0);
      queue_request(OP_REMOVE, 8'd0, 32'hFFFF_FFFF, 1'b0);
      queue_request(OP_GET, 8'd0, 32'h0, 1'b0);
      queue_request(OP_REMOVE, 8'd0, 32'h5A5A_5A5A, 1'b0);
      queue_request(OP_GET, 8'd0, 32'h0, 1'b0);
      queue_request(OP_SET, 8'd0, 32'h1234_5678, 1'b0);

      pool[0] = 32'h0;
      pool[1] = 32'hFFFF_FFFF;
      for (k = 2; k < 16; k++) pool[4'(k)] = $urandom;

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         mode = seg_plan[4'(k / SEGMENT)];
         n = steer_list.size();
         roll = $urandom_range(99, 0);
         case (mode)
            GEN_FILL: begin
               op = (roll < 85) ? OP_PUSH : (roll < 90) ? OP_REMOVE
                  : (roll < 95) ? OP_GET : OP_SET;
            end
            GEN_DRAIN: begin
               op = (roll < 10) ? OP_PUSH : (roll < 75) ? OP_REMOVE
                  : (roll < 88) ? OP_GET : OP_SET;
            end
            default: begin
               op = 2'($urandom_range(3, 0));
            end
         endcase

         pos_roll = $urandom_range(99, 0);
         if (n != 0 && pos_roll < 65) begin
            pos = 8'($urandom_range(n - 1, 0));
         end else if (pos_roll < 80) begin
            pos = (n >= DEPTH) ? 8'(DEPTH - 1) : 8'(n);
         end else if (pos_roll < 85) begin
            pos = (n != 0) ? 8'(n - 1) : 8'd0;
         end else begin
            pos = 8'($urandom);
         end

         roll = $urandom_range(99, 0);
         if (op == OP_REMOVE && n != 0 && roll < 70) begin
            handle = steer_list[$urandom_range(n - 1, 0)];
         end else if (roll < 85) begin
            handle = pool[4'($urandom_range(15, 0))];
         end else begin
            handle = $urandom;
         end
         queue_request(op, pos, handle, k == 650);
      end
      total_reqs = pending_requests.size();

      while (accepted_reqs < total_reqs) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("covered %0d requests, %0d after a drain: push %0d get %0d set %0d remove %0d",
               accepted_reqs, drain_waits, op_seen[OP_PUSH], op_seen[OP_GET],
               op_seen[OP_SET], op_seen[OP_REMOVE]);
      $display("peak fill %0d; ok %0d range %0d full %0d absent %0d; %0d words checked, %0d bad",
               peak_fill, status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
               status_seen[ST_ABSENT], checked_words, mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // long receiver hold-off so the table backs up into its input
   initial begin
      wait (accepted_reqs >= 250);
      @(posedge clock);
      long_hold = 1'b1;
      repeat (400) @(posedge clock);
      long_hold = 1'b0;
   end

   // request driver
   always @(negedge clock) begin
      int sender_idle_pct;
      sender_idle_pct = (idle_phase() == 0) ? 23 : (idle_phase() == 1) ? 64 : 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() != 0
             && !(pending_requests[0].wait_idle && expected_results.size() != 0)
             && $urandom_range(99, 0) >= sender_idle_pct) begin
            if (pending_requests[0].wait_idle) drain_waits++;
            req_valid    <= 1'b1;
            req_op       <= pending_requests[0].op;
            req_position <= pending_requests[0].position;
            req_handle   <= pending_requests[0].handle;
            pending_requests.pop_front();
         end else begin
            req_valid    <= 1'b0;
            req_op       <= 2'($urandom);
            req_position <= 8'($urandom);
            req_handle   <= $urandom;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      int receiver_idle_pct;
      receiver_idle_pct = (idle_phase() == 0) ? 64 : (idle_phase() == 1) ? 23 : 0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= long_hold || $urandom_range(99, 0) < receiver_idle_pct;
      end
   end

   // monitor: check delivered words, then predict newly accepted ones
   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            got.read_value = rsp_read_value;
            got.fill_count = rsp_fill_count;
            got.status     = rsp_status;
            checked_words++;
            if (expected_results.size() == 0) begin
               flag_mismatch("word with nothing expected", '0, got);
            end else begin
               want = expected_results.pop_front();
               if (got.read_value !== want.read_value || got.fill_count !== want.fill_count
                   || got.status !== want.status) begin
                  flag_mismatch("field differs", want, got);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_list_request(req_op, req_position, req_handle);
            expected_results.push_back(want);
            accepted_reqs++;
            op_seen[req_op]++;
            status_seen[want.status]++;
            if (int'(table_count) > peak_fill) peak_fill = int'(table_count);
         end
      end
   end

endmodule

FILE: sim.f
sv/clt_pkg.sv
sv/clt_cell.sv
sv/clt_group.sv
sv/compacting_list_table_core.sv
test/tb_compacting_list_table_core.sv
